/* rtl/contact_bias_and_friction_clamp_assert.svh */
// Assertion macros used by the RTL checker file (rtl/cbfc_checker.sv).
`ifndef CONTACT_BIAS_AND_FRICTION_CLAMP_ASSERT_SVH
`define CONTACT_BIAS_AND_FRICTION_CLAMP_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define CBFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cbfc assertion failed");

// Property must never hold out of reset.
`define CBFC_ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("cbfc forbidden condition seen");

`endif

/* rtl/cbfc_pkg.sv */
package cbfc_pkg;

  typedef enum logic [2:0] {
    CfgStepTime      = 3'd0,
    CfgSlopNormal    = 3'd1,
    CfgSlopNoResp    = 3'd2,
    CfgGainNormal    = 3'd3,
    CfgGainNoResp    = 3'd4,
    CfgKeepMargin    = 3'd5,
    CfgFrictionCoeff = 3'd6
  } cfg_idx_e;

  localparam int unsigned FrontStages = 5;
  localparam int unsigned RootBits    = 32;
  localparam int unsigned QuotBits    = 32;
  localparam int unsigned Latency     = FrontStages + RootBits + 1 + QuotBits + 1;

  typedef struct packed {
    logic [31:0] depth;
    logic [31:0] cached_normal_impulse;
    logic [31:0] cached_friction_one;
    logic [31:0] cached_friction_two;
    logic        no_response_a;
    logic        no_response_b;
  } in_t;

  typedef struct packed {
    logic        active;
    logic [31:0] normal_impulse;
    logic [31:0] friction_one;
    logic [31:0] friction_two;
    logic [31:0] bias_velocity;
  } res_t;

  typedef struct packed {
    logic [30:0] step_time;
    logic [30:0] slop_normal;
    logic [30:0] slop_no_response;
    logic [30:0] gain_normal;
    logic [30:0] gain_no_response;
    logic [30:0] keep_margin;
    logic [30:0] friction_coeff;
  } cfg_t;

  // front end result, one point ready for root and divide
  typedef struct packed {
    logic        active;
    logic [31:0] nimp;
    logic [31:0] f1;
    logic [31:0] f2;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] ar;
    logic        rneg;
    logic        big;
    logic        pos;
    logic        sat;
    logic [61:0] prod;
    logic [63:0] len2;
  } fr_t;

  typedef struct packed {
    logic        active;
    logic [31:0] nimp;
    logic [31:0] f1;
    logic [31:0] f2;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] ar;
    logic        rneg;
    logic        big;
  } sq_tag_t;

  typedef struct packed {
    logic pos;
    logic sat;
  } bias_tag_t;

  typedef struct packed {
    logic        active;
    logic [31:0] nimp;
    logic [31:0] f1;
    logic [31:0] f2;
    logic        big;
    logic        lenz;
    logic        neg1;
    logic [31:0] bias;
  } fd_tag_t;

  function automatic logic [31:0] abs32(logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

  // signed result from magnitude q <= 2^31, saturated to 32 bits
  function automatic logic [31:0] sign_sat(logic [31:0] q, logic neg);
    logic [31:0] r;
    if (neg) begin
      r = 32'd0 - q;
    end else if (q[31]) begin
      r = 32'h7FFF_FFFF;
    end else begin
      r = q;
    end
    return r;
  endfunction

endpackage

/* rtl/contact_bias_and_friction_clamp.sv */
// Channel   Signals                                Handshake
// request   start_i, in_i                          taken when start_i && !busy_o
// result    done_o, res_o                          one-cycle strobe, no back-pressure
// config    cfg_we_i, cfg_idx_i, cfg_data_i        written on each cycle with cfg_we_i
//
// One request per cycle; each result passes through 5 front stages (multiplies,
// cone test), a 32-stage square root, one product stage, a 32-stage divider and
// the output register. Bias division runs beside the root. busy_o stays low.
// Reset clears valid bits and loads the register defaults; the receiver cannot
// stall, so the pipe never holds.
module contact_bias_and_friction_clamp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  cbfc_pkg::in_t    in_i,
  output logic             done_o,
  output cbfc_pkg::res_t   res_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [30:0]      cfg_data_i
);

  localparam int unsigned SqTw   = $bits(cbfc_pkg::sq_tag_t);
  localparam int unsigned BiasTw = $bits(cbfc_pkg::bias_tag_t);
  localparam int unsigned FdTw   = $bits(cbfc_pkg::fd_tag_t);

  cbfc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_time        <= 31'd1092;
      cfg_q.slop_normal      <= 31'd46;
      cfg_q.slop_no_response <= 31'd46;
      cfg_q.gain_normal      <= 31'd39322;
      cfg_q.gain_no_response <= 31'd39322;
      cfg_q.keep_margin      <= 31'd328;
      cfg_q.friction_coeff   <= 31'd39322;
    end else if (cfg_we_i) begin
      unique case (cbfc_pkg::cfg_idx_e'(cfg_idx_i))
        cbfc_pkg::CfgStepTime:      cfg_q.step_time        <= cfg_data_i;
        cbfc_pkg::CfgSlopNormal:    cfg_q.slop_normal      <= cfg_data_i;
        cbfc_pkg::CfgSlopNoResp:    cfg_q.slop_no_response <= cfg_data_i;
        cbfc_pkg::CfgGainNormal:    cfg_q.gain_normal      <= cfg_data_i;
        cbfc_pkg::CfgGainNoResp:    cfg_q.gain_no_response <= cfg_data_i;
        cbfc_pkg::CfgKeepMargin:    cfg_q.keep_margin      <= cfg_data_i;
        cbfc_pkg::CfgFrictionCoeff: cfg_q.friction_coeff   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // front end
  logic          fr_vld;
  cbfc_pkg::fr_t fr;

  cbfc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .in_i    (in_i),
    .cfg_i   (cfg_q),
    .valid_o (fr_vld),
    .fr_o    (fr)
  );

  // root of the friction length, bias quotient alongside
  cbfc_pkg::sq_tag_t   sq_tag_in;
  cbfc_pkg::bias_tag_t bias_tag_in;
  logic [SqTw-1:0]     sq_tag_out;
  logic [BiasTw-1:0]   bias_tag_out;
  logic                sq_vld, bias_vld;
  logic [31:0]         root, bias_quot;

  always_comb begin
    sq_tag_in.active = fr.active;
    sq_tag_in.nimp   = fr.nimp;
    sq_tag_in.f1     = fr.f1;
    sq_tag_in.f2     = fr.f2;
    sq_tag_in.a1     = fr.a1;
    sq_tag_in.a2     = fr.a2;
    sq_tag_in.ar     = fr.ar;
    sq_tag_in.rneg   = fr.rneg;
    sq_tag_in.big    = fr.big;
    bias_tag_in.pos  = fr.pos;
    bias_tag_in.sat  = fr.sat;
  end

  cbfc_sqrt #(.N(cbfc_pkg::RootBits), .TW(SqTw)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_vld),
    .x_i     (fr.len2),
    .tag_i   (sq_tag_in),
    .valid_o (sq_vld),
    .root_o  (root),
    .tag_o   (sq_tag_out)
  );

  cbfc_div #(.QW(cbfc_pkg::QuotBits), .DW(32), .TW(BiasTw)) u_bias_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (fr_vld),
    .dividend_i ({2'b00, fr.prod}),
    .divisor_i  ({1'b0, cfg_q.step_time}),
    .tag_i      (bias_tag_in),
    .valid_o    (bias_vld),
    .quot_o     (bias_quot),
    .tag_o      (bias_tag_out)
  );

  // product stage
  cbfc_pkg::sq_tag_t   sq_tag;
  cbfc_pkg::bias_tag_t bias_tag;
  cbfc_pkg::fd_tag_t   pm_tag_q;
  logic                pm_vld_q, pm_neg2_q;
  logic [63:0]         pm_p1_q, pm_p2_q;
  logic [31:0]         pm_len_q;
  logic [31:0]         bias_d;

  assign sq_tag   = cbfc_pkg::sq_tag_t'(sq_tag_out);
  assign bias_tag = cbfc_pkg::bias_tag_t'(bias_tag_out);

  always_comb begin
    if (!bias_tag.pos) begin
      bias_d = 32'd0;
    end else if (bias_tag.sat) begin
      bias_d = 32'h8000_0000;
    end else begin
      bias_d = 32'd0 - bias_quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_vld_q <= 1'b0;
    end else begin
      pm_vld_q <= sq_vld && bias_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pm_p1_q         <= 64'(sq_tag.a1) * 64'(sq_tag.ar);
    pm_p2_q         <= 64'(sq_tag.a2) * 64'(sq_tag.ar);
    pm_len_q        <= root;
    pm_neg2_q       <= sq_tag.f2[31] ^ sq_tag.rneg;
    pm_tag_q.active <= sq_tag.active;
    pm_tag_q.nimp   <= sq_tag.nimp;
    pm_tag_q.f1     <= sq_tag.f1;
    pm_tag_q.f2     <= sq_tag.f2;
    pm_tag_q.big    <= sq_tag.big;
    pm_tag_q.lenz   <= root == 32'd0;
    pm_tag_q.neg1   <= sq_tag.f1[31] ^ sq_tag.rneg;
    pm_tag_q.bias   <= bias_d;
  end

  // friction scaling lanes
  logic [FdTw-1:0] fd_tag_out;
  logic            fd_neg2;
  logic            fd_vld, fd2_vld;
  logic [31:0]     q1, q2;

  cbfc_div #(.QW(cbfc_pkg::QuotBits), .DW(32), .TW(FdTw)) u_div_one (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (pm_vld_q),
    .dividend_i (pm_p1_q),
    .divisor_i  (pm_len_q),
    .tag_i      (pm_tag_q),
    .valid_o    (fd_vld),
    .quot_o     (q1),
    .tag_o      (fd_tag_out)
  );

  cbfc_div #(.QW(cbfc_pkg::QuotBits), .DW(32), .TW(1)) u_div_two (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (pm_vld_q),
    .dividend_i (pm_p2_q),
    .divisor_i  (pm_len_q),
    .tag_i      (pm_neg2_q),
    .valid_o    (fd2_vld),
    .quot_o     (q2),
    .tag_o      (fd_neg2)
  );

  // output register
  cbfc_pkg::fd_tag_t fd;
  cbfc_pkg::res_t    res_d, res_q;
  logic              done_q;
  logic              scale;

  assign fd = cbfc_pkg::fd_tag_t'(fd_tag_out);

  always_comb begin
    scale = fd.big && !fd.lenz;
    res_d = '0;
    if (fd.active) begin
      res_d.active         = 1'b1;
      res_d.normal_impulse = fd.nimp;
      res_d.friction_one   = scale ? cbfc_pkg::sign_sat(q1, fd.neg1) : fd.f1;
      res_d.friction_two   = scale ? cbfc_pkg::sign_sat(q2, fd_neg2) : fd.f2;
      res_d.bias_velocity  = fd.bias;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fd_vld && fd2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* rtl/cbfc_front.sv */
module cbfc_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cbfc_pkg::in_t     in_i,
  input  cbfc_pkg::cfg_t    cfg_i,
  output logic              valid_o,
  output cbfc_pkg::fr_t     fr_o
);

  logic [4:0] vld_q;

  // stage 1
  logic        s1_act_q, s1_pos_q;
  logic [31:0] s1_nimp_q, s1_f1_q, s1_f2_q, s1_na_q, s1_a1_q, s1_a2_q;
  logic [30:0] s1_allow_q, s1_gain_q;
  // stage 2
  logic        s2_act_q, s2_pos_q, s2_nneg_q;
  logic [31:0] s2_nimp_q, s2_f1_q, s2_f2_q, s2_a1_q, s2_a2_q;
  logic [61:0] s2_prod_q;
  logic [62:0] s2_mr_q;
  logic [63:0] s2_sq1_q, s2_sq2_q;
  // stage 3
  logic        s3_act_q, s3_pos_q, s3_sat_q, s3_rneg_q;
  logic [31:0] s3_nimp_q, s3_f1_q, s3_f2_q, s3_a1_q, s3_a2_q, s3_ar_q;
  logic [61:0] s3_prod_q;
  logic [63:0] s3_len2_q;
  // stage 4
  logic        s4_act_q, s4_pos_q, s4_sat_q, s4_rneg_q;
  logic [31:0] s4_nimp_q, s4_f1_q, s4_f2_q, s4_a1_q, s4_a2_q, s4_ar_q;
  logic [61:0] s4_prod_q;
  logic [63:0] s4_len2_q, s4_r2_q;
  // stage 5
  cbfc_pkg::fr_t fr_q;

  logic        nr;
  logic [30:0] slop_d, gain_d;
  logic        act_d, pos_d;
  logic [33:0] marg_d;
  logic [32:0] allow_d;
  logic [62:0] msh_d;
  logic [31:0] mc_d, ar_d;

  always_comb begin
    nr      = in_i.no_response_a | in_i.no_response_b;
    slop_d  = nr ? cfg_i.slop_no_response : cfg_i.slop_normal;
    gain_d  = nr ? cfg_i.gain_no_response : cfg_i.gain_normal;
    marg_d  = {{2{in_i.depth[31]}}, in_i.depth} + {3'b000, cfg_i.keep_margin};
    act_d   = !marg_d[33] && (marg_d != 34'd0);
    allow_d = {in_i.depth[31], in_i.depth} - {2'b00, slop_d};
    pos_d   = !allow_d[32] && (allow_d != 33'd0);
  end

  always_comb begin
    msh_d = s2_mr_q >> FRAC_BITS;
    mc_d  = (msh_d > 63'h8000_0000) ? 32'h8000_0000 : msh_d[31:0];
    if (s2_nneg_q) begin
      ar_d = mc_d;
    end else begin
      ar_d = mc_d[31] ? 32'h7FFF_FFFF : mc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_act_q   <= act_d;
    s1_pos_q   <= pos_d;
    s1_nimp_q  <= in_i.cached_normal_impulse;
    s1_f1_q    <= in_i.cached_friction_one;
    s1_f2_q    <= in_i.cached_friction_two;
    s1_na_q    <= cbfc_pkg::abs32(in_i.cached_normal_impulse);
    s1_a1_q    <= cbfc_pkg::abs32(in_i.cached_friction_one);
    s1_a2_q    <= cbfc_pkg::abs32(in_i.cached_friction_two);
    s1_allow_q <= allow_d[30:0];
    s1_gain_q  <= gain_d;

    s2_act_q  <= s1_act_q;
    s2_pos_q  <= s1_pos_q;
    s2_nneg_q <= s1_nimp_q[31];
    s2_nimp_q <= s1_nimp_q;
    s2_f1_q   <= s1_f1_q;
    s2_f2_q   <= s1_f2_q;
    s2_a1_q   <= s1_a1_q;
    s2_a2_q   <= s1_a2_q;
    s2_prod_q <= 62'(s1_gain_q) * 62'(s1_allow_q);
    s2_mr_q   <= 63'(cfg_i.friction_coeff) * 63'(s1_na_q);
    s2_sq1_q  <= 64'(s1_a1_q) * 64'(s1_a1_q);
    s2_sq2_q  <= 64'(s1_a2_q) * 64'(s1_a2_q);

    s3_act_q  <= s2_act_q;
    s3_pos_q  <= s2_pos_q;
    // a zero step time also lands here: the quotient is taken as saturated
    s3_sat_q  <= s2_prod_q[61:31] >= cfg_i.step_time;
    s3_rneg_q <= s2_nneg_q && (mc_d != 32'd0);
    s3_nimp_q <= s2_nimp_q;
    s3_f1_q   <= s2_f1_q;
    s3_f2_q   <= s2_f2_q;
    s3_a1_q   <= s2_a1_q;
    s3_a2_q   <= s2_a2_q;
    s3_ar_q   <= ar_d;
    s3_prod_q <= s2_prod_q;
    s3_len2_q <= s2_sq1_q + s2_sq2_q;

    s4_act_q  <= s3_act_q;
    s4_pos_q  <= s3_pos_q;
    s4_sat_q  <= s3_sat_q;
    s4_rneg_q <= s3_rneg_q;
    s4_nimp_q <= s3_nimp_q;
    s4_f1_q   <= s3_f1_q;
    s4_f2_q   <= s3_f2_q;
    s4_a1_q   <= s3_a1_q;
    s4_a2_q   <= s3_a2_q;
    s4_ar_q   <= s3_ar_q;
    s4_prod_q <= s3_prod_q;
    s4_len2_q <= s3_len2_q;
    s4_r2_q   <= 64'(s3_ar_q) * 64'(s3_ar_q);

    fr_q.active <= s4_act_q;
    fr_q.nimp   <= s4_nimp_q;
    fr_q.f1     <= s4_f1_q;
    fr_q.f2     <= s4_f2_q;
    fr_q.a1     <= s4_a1_q;
    fr_q.a2     <= s4_a2_q;
    fr_q.ar     <= s4_ar_q;
    fr_q.rneg   <= s4_rneg_q;
    fr_q.big    <= s4_len2_q > s4_r2_q;
    fr_q.pos    <= s4_pos_q;
    fr_q.sat    <= s4_sat_q;
    fr_q.prod   <= s4_prod_q;
    fr_q.len2   <= s4_len2_q;
  end

  assign valid_o = vld_q[4];
  assign fr_o    = fr_q;

endmodule

/* rtl/cbfc_sqrt.sv */
module cbfc_sqrt #(
  parameter int unsigned N  = 32,
  parameter int unsigned TW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*N-1:0]  x_i,
  input  logic [TW-1:0]   tag_i,
  output logic            valid_o,
  output logic [N-1:0]    root_o,
  output logic [TW-1:0]   tag_o
);

  localparam int unsigned RW = N + 3;

  logic [RW-1:0]  rem_q  [N];
  logic [N-1:0]   root_q [N];
  logic [2*N-1:0] xs_q   [N];
  logic [TW-1:0]  tag_q  [N];
  logic [N-1:0]   vld_q;

  for (genvar s = 0; s < N; s++) begin : g_step
    logic [RW-1:0]  rem_in, t, trial;
    logic [N-1:0]   root_in;
    logic [2*N-1:0] xs_in;
    logic [TW-1:0]  tag_in;
    logic           vld_in, ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign xs_in   = x_i;
      assign tag_in  = tag_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign xs_in   = xs_q[s-1];
      assign tag_in  = tag_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    // remainder stays below 2*root + 1, so the top two bits are free
    assign t     = {rem_in[RW-3:0], xs_in[2*N-1:2*N-2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? (t - trial) : t;
      root_q[s] <= {root_in[N-2:0], ge};
      xs_q[s]   <= {xs_in[2*N-3:0], 2'b00};
      tag_q[s]  <= tag_in;
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign tag_o   = tag_q[N-1];

endmodule

/* rtl/cbfc_div.sv */
module cbfc_div #(
  parameter int unsigned QW = 32,
  parameter int unsigned DW = 32,
  parameter int unsigned TW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [QW+DW-1:0]  dividend_i,
  input  logic [DW-1:0]     divisor_i,
  input  logic [TW-1:0]     tag_i,
  output logic              valid_o,
  output logic [QW-1:0]     quot_o,
  output logic [TW-1:0]     tag_o
);

  // restoring division, one quotient bit per stage; needs dividend >> QW < divisor
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [DW-1:0] dv_q  [QW];
  logic [TW-1:0] tag_q [QW];
  logic [QW-1:0] vld_q;

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DW-1:0] rem_in, dv_in;
    logic [QW-1:0] lo_in;
    logic [TW-1:0] tag_in;
    logic          vld_in, ge;
    logic [DW:0]   t;

    if (s == 0) begin : g_first
      assign rem_in = dividend_i[QW+DW-1:QW];
      assign lo_in  = dividend_i[QW-1:0];
      assign dv_in  = divisor_i;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign lo_in  = lo_q[s-1];
      assign dv_in  = dv_q[s-1];
      assign tag_in = tag_q[s-1];
      assign vld_in = vld_q[s-1];
    end

    assign t  = {rem_in, lo_in[QW-1]};
    assign ge = t >= {1'b0, dv_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? DW'(t - {1'b0, dv_in}) : t[DW-1:0];
      lo_q[s]  <= {lo_in[QW-2:0], ge};
      dv_q[s]  <= dv_in;
      tag_q[s] <= tag_in;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = lo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

/* rtl/cbfc_checker.sv */
`include "contact_bias_and_friction_clamp_assert.svh"

module cbfc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_i,
  input logic           done_i,
  input cbfc_pkg::res_t res_i
);

  logic fields_zero;

  assign fields_zero = (res_i.normal_impulse == 32'd0) && (res_i.friction_one == 32'd0) &&
                       (res_i.friction_two == 32'd0) && (res_i.bias_velocity == 32'd0);

  `CBFC_ASSERT_NEVER(a_never_busy, busy_i)

  `CBFC_ASSERT(a_done_latency, done_i |-> $past(start_i && !busy_i, cbfc_pkg::Latency))

  `CBFC_ASSERT(a_inactive_zero, (done_i && !res_i.active) |-> fields_zero)

  `CBFC_ASSERT(a_bias_not_pos, done_i |-> (res_i.bias_velocity[31] || fields_zero || res_i.bias_velocity == 32'd0))

endmodule

bind contact_bias_and_friction_clamp cbfc_checker u_cbfc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_i  (busy_o),
  .done_i  (done_o),
  .res_i   (res_o)
);

/* tb/sv/cbfc_checker.sv */
`timescale 1ns / 100ps

module cbfc_tb_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  cbfc_pkg::in_t    in_i,
  input  logic             done_i,
  input  cbfc_pkg::res_t   res_i,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [30:0]      cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  import cbfc_pkg::*;

  cfg_t cfg_q;
  res_t contact_q[$];

  function automatic longint sat_s32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // scale one tangent impulse onto the cone, truncated toward zero
  function automatic longint cone_scale(longint f, longint rad, longint unsigned len);
    longint unsigned q;
    logic neg;
    neg = (f < 0) != (rad < 0);
    q = (longint'(f < 0 ? -f : f) * longint'(rad < 0 ? -rad : rad)) / len;
    if (q > 64'h7FFF_FFFF_FFFF) q = 64'h7FFF_FFFF_FFFF;
    return sat_s32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic res_t prepare_contact(in_t p, cfg_t c);
    res_t r;
    longint depth, nimp, f1, f2, allowed, rad;
    longint unsigned slop, gain, prod, q, m, a1, a2, ar, len2, len;
    logic nr;
    r = '0;
    depth = longint'($signed(p.depth));
    nimp = longint'($signed(p.cached_normal_impulse));
    f1 = longint'($signed(p.cached_friction_one));
    f2 = longint'($signed(p.cached_friction_two));
    nr = p.no_response_a | p.no_response_b;
    slop = nr ? c.slop_no_response : c.slop_normal;
    gain = nr ? c.gain_no_response : c.gain_normal;
    if (!(depth > -longint'(c.keep_margin))) return r;
    r.active = 1'b1;
    allowed = depth - longint'(slop);
    if (allowed > 0) begin
      prod = gain * longint'(allowed);
      q = 64'h8000_0000;
      if (c.step_time != 0) q = prod / c.step_time;
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      r.bias_velocity = 32'(-longint'(q));
    end
    m = (longint'(c.friction_coeff) * longint'(nimp < 0 ? -nimp : nimp)) >> FRAC_BITS;
    if (m > 64'h8000_0000) m = 64'h8000_0000;
    rad = sat_s32(nimp < 0 ? -longint'(m) : longint'(m));
    a1 = f1 < 0 ? -f1 : f1;
    a2 = f2 < 0 ? -f2 : f2;
    ar = rad < 0 ? -rad : rad;
    len2 = a1 * a1 + a2 * a2;
    if (len2 > ar * ar) begin
      len = root64(len2);
      if (len > 0) begin
        f1 = cone_scale(f1, rad, len);
        f2 = cone_scale(f2, rad, len);
      end
    end
    r.normal_impulse = 32'(nimp);
    r.friction_one = 32'(f1);
    r.friction_two = 32'(f2);
    return r;
  endfunction

  assign pending_o = contact_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      cfg_q <= '{step_time: 31'd1092, slop_normal: 31'd46, slop_no_response: 31'd46,
                 gain_normal: 31'd39322, gain_no_response: 31'd39322,
                 keep_margin: 31'd328, friction_coeff: 31'd39322};
      fail_count_o <= 0;
      contact_q.delete();
    end else begin
      if (done_i) begin
        if (contact_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = contact_q.pop_front();
          if (e != res_i) begin
            fail_count_o <= fail_count_o + 1;
            if (e.active != res_i.active)
              $error("active exp %0d got %0d", e.active, res_i.active);
            if (e.normal_impulse != res_i.normal_impulse)
              $error("normal_impulse exp %h got %h", e.normal_impulse, res_i.normal_impulse);
            if (e.friction_one != res_i.friction_one)
              $error("friction_one exp %h got %h", e.friction_one, res_i.friction_one);
            if (e.friction_two != res_i.friction_two)
              $error("friction_two exp %h got %h", e.friction_two, res_i.friction_two);
            if (e.bias_velocity != res_i.bias_velocity)
              $error("bias_velocity exp %h got %h", e.bias_velocity, res_i.bias_velocity);
          end
        end
      end
      if (start_i && !busy_i) contact_q = {contact_q, prepare_contact(in_i, cfg_q)};
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgStepTime:      cfg_q.step_time <= cfg_data_i;
          CfgSlopNormal:    cfg_q.slop_normal <= cfg_data_i;
          CfgSlopNoResp:    cfg_q.slop_no_response <= cfg_data_i;
          CfgGainNormal:    cfg_q.gain_normal <= cfg_data_i;
          CfgGainNoResp:    cfg_q.gain_no_response <= cfg_data_i;
          CfgKeepMargin:    cfg_q.keep_margin <= cfg_data_i;
          CfgFrictionCoeff: cfg_q.friction_coeff <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

/* tb/sv/tb_contact_bias_and_friction_clamp.sv */
`timescale 1ns / 100ps

module tb_contact_bias_and_friction_clamp;
  import cbfc_pkg::*;

  localparam int WatchLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  in_t in_i = '0;
  logic done_o;
  res_t res_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;
  int fail_count, pending;
  int idle_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  contact_bias_and_friction_clamp u_top (.*);

  cbfc_tb_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .in_i, .done_i(done_o), .res_i(res_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog: cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] edge_val();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'(int'($urandom_range(0, 4000)) - 2000);
      5: return 32'($urandom_range(0, 32'h0004_0000));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] cfg_val();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return 31'd1;
      3: return 31'($urandom_range(0, 32'h0002_0000));
      default: return 31'($urandom());
    endcase
  endfunction

  // write enable stays up across back-to-back writes; caller drops it
  task automatic write_reg(cfg_idx_e idx, logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic send_point(in_t p, int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= p;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic run_points(int n, bit dense);
    in_t p;
    for (int i = 0; i < n; i++) begin
      p.depth = edge_val();
      p.cached_normal_impulse = edge_val();
      p.cached_friction_one = edge_val();
      p.cached_friction_two = edge_val();
      p.no_response_a = $urandom_range(0, 1);
      p.no_response_b = $urandom_range(0, 1);
      send_point(p, dense ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0));
    end
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    in_t p;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, flags, inactive boundary, zero length pair
    for (int i = 0; i < 20; i++) begin
      p = '0;
      p.depth = (i < 4) ? 32'hFFFF_FEB8 + i - 1 : ((i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
      p.cached_normal_impulse = (i % 3 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      p.cached_friction_one = (i % 4 == 0) ? 32'h0 : 32'h8000_0000 >> (i % 3);
      p.cached_friction_two = (i % 5 == 0) ? 32'h0 : 32'h7FFF_FFFF;
      p.no_response_a = i[0];
      p.no_response_b = i[1];
      if (i >= 4) p.depth = (i < 12) ? 32'd46 + i - 8 : p.depth;
      send_point(p, 0);
    end
    start_i <= 1'b0;
    drain();
    write_reg(CfgStepTime, 31'd0);
    write_reg(CfgSlopNormal, 31'd0);
    write_reg(CfgSlopNoResp, 31'h7FFF_FFFF);
    write_reg(CfgGainNormal, 31'h7FFF_FFFF);
    write_reg(CfgGainNoResp, 31'd0);
    write_reg(CfgKeepMargin, 31'h7FFF_FFFF);
    write_reg(CfgFrictionCoeff, 31'h7FFF_FFFF);
    cfg_we_i <= 1'b0;
    run_points(200, 1'b1);
    drain();
    for (int ph = 0; ph < 7; ph++) begin
      for (int r = 0; r < 7; r++) write_reg(cfg_idx_e'(r), cfg_val());
      cfg_we_i <= 1'b0;
      run_points(200, ph[0]);
      drain();
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* contact_bias_and_friction_clamp.f */
+incdir+rtl
rtl/cbfc_pkg.sv
rtl/cbfc_front.sv
rtl/cbfc_sqrt.sv
rtl/cbfc_div.sv
rtl/contact_bias_and_friction_clamp.sv
rtl/cbfc_checker.sv
tb/sv/cbfc_checker.sv
tb/sv/tb_contact_bias_and_friction_clamp.sv
